/* rtl/bspc_pkg.sv */
// ----------------------------------------------------------------------------
// bspc_pkg: shared types and constants of the stack permutation checker
// Field widths, register indexes, reset values and the command and status
// bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bspc_pkg;

  localparam int TARGET_W    = 21;
  localparam int CAPACITY_W  = 11;
  localparam int CAR_COUNT_W = 21;
  // next arrival can run one past the largest target
  localparam int ARRIVAL_W   = TARGET_W + 1;

  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 21;

  localparam logic [CFG_ADDR_W-1:0] CFG_CAPACITY  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CAR_COUNT = 1'd1;

  localparam logic [CAPACITY_W-1:0]  CAPACITY_RST  = 11'd1024;
  localparam logic [CAR_COUNT_W-1:0] CAR_COUNT_RST = 21'd1048576;

  localparam int STACK_DEPTH_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 21;

  typedef struct packed {
    logic load;   // capture a new beat
    logic push;   // push next arrival onto the stack
    logic pass;   // next arrival passes straight through
    logic pop;    // read top of stack and drop it
    logic fail;   // mark the sequence failed
    logic emit;   // load the result register
  } cmd_t;

  typedef struct packed {
    logic failed;
    logic bad_target;
    logic arr_lt;
    logic arr_eq;
    logic full;
    logic empty;
    logic match;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/bounded_stack_permutation_checker.sv */
// ----------------------------------------------------------------------------
// bounded_stack_permutation_checker: stack permutation feasibility check
// Sequence: idle accepts a beat; check pushes one arrival per cycle, then
//   passes, pops or fails; a pop adds a compare state (registered stack read);
//   result waits for a free result register. A new beat is taken only after
//   the verdict is loaded; the push loop uses the single stack RAM write port.
// Reset: synchronous, active low; empties the stack, sets the next arrival
//   to one, clears failure and result valid, restores the register defaults;
//   the stack RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_permutation_checker #(
  parameter int STACK_DEPTH = bspc_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = bspc_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [bspc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [bspc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // departing order, one car number per beat
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [bspc_pkg::TARGET_W-1:0]   in_target,
  input  wire logic                            in_last,
  // one verdict per input beat
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_feasible,
  output logic                                 out_done_res
);

  bspc_pkg::cmd_t cmd;
  bspc_pkg::sts_t sts;

  // Controller: idle, decide (push loop / pass / pop), pop compare, result.
  // It accepts a new beat as soon as it is idle, even while the previous
  // verdict still waits in the result register.
  bspc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: config, stack state, stack RAM and the result register.
  bspc_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_target    (in_target),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_feasible (out_feasible),
    .out_done_res (out_done_res),
    .cmd          (cmd),
    .sts          (sts)
  );

`ifndef SYNTHESIS
  // never push into a full stack
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.full)
    else $error("push issued with full stack");

  // commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.push, cmd.pass, cmd.pop, cmd.fail, cmd.emit}))
    else $error("more than one command in a cycle");

  // a verdict is only loaded when the result register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result overwritten before it was taken");

  // once a beat is taken the block is busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat accepted back to back");
`endif

endmodule

`default_nettype wire

/* rtl/bspc_ram.sv */
// ----------------------------------------------------------------------------
// bspc_ram: generic single-port-write RAM with registered read
// One write and one read port; read data appears the cycle after re.
// ----------------------------------------------------------------------------
`default_nettype none

module bspc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/bspc_ctrl.sv */
// ----------------------------------------------------------------------------
// bspc_ctrl: sequencer of the stack permutation checker
// Walks one beat through push, pass-through or pop, then hands the verdict
// to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bspc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bspc_pkg::sts_t sts,
  output bspc_pkg::cmd_t     cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_POP    = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.failed) begin
          state_nxt = S_RESULT;
        end else if (sts.bad_target) begin
          cmd.fail  = 1'b1;
          state_nxt = S_RESULT;
        end else if (sts.arr_lt) begin
          // stay here, one push a cycle
          if (sts.full) begin
            cmd.fail  = 1'b1;
            state_nxt = S_RESULT;
          end else begin
            cmd.push = 1'b1;
          end
        end else if (sts.arr_eq) begin
          if (sts.full) begin
            cmd.fail = 1'b1;
          end else begin
            cmd.pass = 1'b1;
          end
          state_nxt = S_RESULT;
        end else if (sts.empty) begin
          cmd.fail  = 1'b1;
          state_nxt = S_RESULT;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        cmd.fail  = !sts.match;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/bspc_dp.sv */
// ----------------------------------------------------------------------------
// bspc_dp: datapath of the stack permutation checker
// Configuration, stack level, next arrival, sticky failure, stack RAM and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bspc_dp #(
  parameter int STACK_DEPTH = bspc_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = bspc_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [bspc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [bspc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [bspc_pkg::TARGET_W-1:0]   in_target,
  input  wire logic                            in_last,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_feasible,
  output logic                                 out_done_res,
  input  wire bspc_pkg::cmd_t                  cmd,
  output bspc_pkg::sts_t                       sts
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W  = (LVL_W > bspc_pkg::CAPACITY_W) ? LVL_W : bspc_pkg::CAPACITY_W;
  localparam int ARR_W  = bspc_pkg::ARRIVAL_W;
  localparam int TGT_W  = bspc_pkg::TARGET_W;

  logic [bspc_pkg::CAPACITY_W-1:0]  capacity_r;
  logic [bspc_pkg::CAR_COUNT_W-1:0] car_count_r;
  logic [LVL_W-1:0]                 level_r;
  logic [ARR_W-1:0]                 arrival_r;
  logic                             failed_r;
  logic [TGT_W-1:0]                 target_r;
  logic                             last_r;
  logic                             out_valid_r;
  logic                             out_feasible_r;
  logic                             out_done_res_r;

  logic [CMP_W-1:0]       cap_ext, lim, level_ext;
  logic [LVL_W-1:0]       level_dec;
  logic [VALUE_WIDTH-1:0] wdata, tgt_val, rdata;
  logic [ARR_W-1:0]       target_ext, car_count_ext;
  logic                   ok;

  // clamp capacity to the physical depth
  assign cap_ext   = CMP_W'(capacity_r);
  assign lim       = (cap_ext > CMP_W'(STACK_DEPTH)) ? CMP_W'(STACK_DEPTH) : cap_ext;
  assign level_ext = CMP_W'(level_r);
  assign level_dec = level_r - LVL_W'(1);

  assign target_ext    = ARR_W'(target_r);
  assign car_count_ext = ARR_W'(car_count_r);

  // stored values are the arrival number cut to the stack word width
  for (genvar i = 0; i < VALUE_WIDTH; i++) begin : g_val
    if (i < ARR_W) begin : g_wr
      assign wdata[i] = arrival_r[i];
    end else begin : g_wr_zero
      assign wdata[i] = 1'b0;
    end
    if (i < TGT_W) begin : g_tg
      assign tgt_val[i] = target_r[i];
    end else begin : g_tg_zero
      assign tgt_val[i] = 1'b0;
    end
  end

  bspc_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (level_r[ADDR_W-1:0]),
    .wdata (wdata),
    .re    (cmd.pop),
    .raddr (level_dec[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    sts            = '0;
    sts.failed     = failed_r;
    sts.bad_target = (target_r == '0) || (target_ext > car_count_ext);
    sts.arr_lt     = arrival_r < target_ext;
    sts.arr_eq     = arrival_r == target_ext;
    sts.full       = level_ext >= lim;
    sts.empty      = level_r == '0;
    sts.match      = rdata == tgt_val;
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign ok = !failed_r && (!last_r || ((level_r == '0) && (arrival_r > car_count_ext)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= bspc_pkg::CAPACITY_RST;
      car_count_r <= bspc_pkg::CAR_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        bspc_pkg::CFG_CAPACITY:  capacity_r  <= cfg_wdata[bspc_pkg::CAPACITY_W-1:0];
        bspc_pkg::CFG_CAR_COUNT: car_count_r <= cfg_wdata[bspc_pkg::CAR_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      arrival_r   <= ARR_W'(1);
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.push) begin
        level_r   <= level_r + LVL_W'(1);
        arrival_r <= arrival_r + ARR_W'(1);
      end
      if (cmd.pass) begin
        arrival_r <= arrival_r + ARR_W'(1);
      end
      if (cmd.pop) begin
        level_r <= level_dec;
      end
      if (cmd.fail) begin
        failed_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (last_r) begin
          // end of sequence: start the next one fresh
          level_r   <= '0;
          arrival_r <= ARR_W'(1);
          failed_r  <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target_r <= in_target;
      last_r   <= in_last;
    end
    if (cmd.emit) begin
      out_feasible_r <= ok;
      out_done_res_r <= last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_feasible = out_feasible_r;
  assign out_done_res = out_done_res_r;

endmodule

`default_nettype wire

/* tb/bounded_stack_permutation_checker_tb.sv */
// ----------------------------------------------------------------------------
// bounded_stack_permutation_checker_tb: self-checking bench for the checker
// Drives departing orders of cars over the valid/ready input, predicts each
// verdict from a behavioral copy of the bounded-stack rules, and checks every
// result beat against that prediction in order. Directed cases come first,
// then stack-realizable random orders with random corruption and noise.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_permutation_checker_tb;
  import bspc_pkg::*;

  localparam int STACK_CAP_MAX = STACK_DEPTH_DEF;
  localparam int RUN_LIMIT     = 4000000;
  localparam int RANDOM_BEATS  = 750;

  typedef struct packed {
    logic feasible;
    logic done;
  } verdict_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_CAPACITY;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [TARGET_W-1:0]   in_target = '0;
  logic                  in_last   = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_feasible;
  logic                  out_done_res;

  // shadow of the block: configuration and sequence state
  logic [CAPACITY_W-1:0]  cap_reg       = CAPACITY_RST;
  logic [CAR_COUNT_W-1:0] car_count_reg = CAR_COUNT_RST;
  logic [TARGET_W-1:0]    car_stack [STACK_CAP_MAX];
  int unsigned            stack_level   = 0;
  logic [ARRIVAL_W-1:0]   next_arrival  = 1;
  bit                     seq_failed    = 1'b0;

  verdict_t verdict_q [$];

  bit          no_stall        = 1'b0;
  int unsigned errors          = 0;
  int unsigned beats_sent      = 0;
  int unsigned verdicts_seen   = 0;
  int unsigned finals          = 0;
  int unsigned feasible_finals = 0;
  int unsigned settings        = 0;
  int unsigned cycle_count     = 0;

  bounded_stack_permutation_checker uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_target   (in_target),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_feasible(out_feasible),
    .out_done_res(out_done_res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: a hung handshake or a lost verdict ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached, %0d verdicts outstanding",
               $time, RUN_LIMIT, verdict_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stalls at random, about 19 times in 100, unless a steady stretch runs.
  always @(posedge clk) begin
    if (no_stall) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 19);
    end
  end

  // Place one target car: push arrivals below it, let it pass if it is next,
  // else pop and compare. Returns 0 on any failure.
  function automatic bit place_car(logic [TARGET_W-1:0] target);
    int unsigned room;
    room = (cap_reg > STACK_CAP_MAX) ? STACK_CAP_MAX : cap_reg;
    // zero or beyond the last car can never depart
    if (target == 0 || target > car_count_reg) return 1'b0;
    while (next_arrival < target) begin
      // full stack on push
      if (stack_level >= room) return 1'b0;
      car_stack[stack_level] = next_arrival[TARGET_W-1:0];
      stack_level++;
      next_arrival++;
    end
    if (next_arrival == target) begin
      // pass-through still takes a free slot
      if (stack_level >= room) return 1'b0;
      next_arrival++;
      return 1'b1;
    end
    // pop of an empty stack fails
    if (stack_level == 0) return 1'b0;
    stack_level--;
    return car_stack[stack_level] == target;
  endfunction

  // Work out the verdict of one accepted beat and queue it.
  function automatic void judge_beat(logic [TARGET_W-1:0] target, logic last);
    verdict_t v;
    // failure is sticky: no state moves once failed
    if (!seq_failed && !place_car(target)) seq_failed = 1'b1;
    v.feasible = !seq_failed;
    // final verdict also needs an empty stack and every car arrived
    if (last) v.feasible = v.feasible && stack_level == 0 && next_arrival > car_count_reg;
    v.done = last;
    verdict_q.push_back(v);
    if (last) begin
      finals++;
      if (v.feasible) feasible_finals++;
      // start a fresh sequence; the stack contents stay
      stack_level  = 0;
      next_arrival = 1;
      seq_failed   = 1'b0;
    end
  endfunction

  // Compare one result beat against the oldest queued verdict.
  function automatic void check_verdict();
    verdict_t want;
    if (verdict_q.size() == 0) begin
      $display("%0t: verdict beat with none expected: feasible %0b done %0b",
               $time, out_feasible, out_done_res);
      errors++;
      return;
    end
    want = verdict_q.pop_front();
    verdicts_seen++;
    if (out_feasible !== want.feasible) begin
      $display("%0t: feasible mismatch: expected %0b actual %0b",
               $time, want.feasible, out_feasible);
      errors++;
    end
    if (out_done_res !== want.done) begin
      $display("%0t: done_res mismatch: expected %0b actual %0b",
               $time, want.done, out_done_res);
      errors++;
    end
  endfunction

  // Both sides of the block are sampled at the same edge, input side first.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) judge_beat(in_target, in_last);
    if (rst_n && out_valid && out_ready) check_verdict();
  end

  // Send one beat. Hold valid across back-to-back beats; drop it only for a
  // random gap so a valid is never lowered and raised in one step.
  task automatic send_car(int unsigned target, bit last);
    if (!no_stall && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_target <= target[TARGET_W-1:0];
    in_last   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  // Drop valid and wait for every queued verdict, then a short settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write both registers while idle and mirror them in the shadow state.
  task automatic set_config(int unsigned cap, int unsigned count);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_CAPACITY;
    cfg_wdata <= CFG_DATA_W'(cap[CAPACITY_W-1:0]);
    @(posedge clk);
    cfg_addr  <= CFG_CAR_COUNT;
    cfg_wdata <= count[CAR_COUNT_W-1:0];
    @(posedge clk);
    cfg_we        <= 1'b0;
    cap_reg       = cap[CAPACITY_W-1:0];
    car_count_reg = count[CAR_COUNT_W-1:0];
    settings++;
    @(posedge clk);
  endtask

  // Reset values: huge car count, full-size stack.
  task automatic test_default_config();
    send_car(1, 1'b0);
    // out of range, then a new sequence
    send_car(2097151, 1'b1);
    // top-bit target: pushes until the stack fills, then fails
    send_car(1048576, 1'b1);
  endtask

  task automatic test_small_orders();
    set_config(3, 3);
    // reversal through the stack
    send_car(3, 1'b0);
    send_car(2, 1'b0);
    send_car(1, 1'b1);
    // wrong pop, then a sticky failure
    send_car(3, 1'b0);
    send_car(1, 1'b0);
    send_car(2, 1'b1);
    // target zero
    send_car(0, 1'b1);
    // pop of an empty stack
    send_car(1, 1'b0);
    send_car(1, 1'b1);
    // last beat with cars still on the stack
    send_car(2, 1'b1);
  endtask

  task automatic test_tight_stack();
    set_config(1, 3);
    send_car(1, 1'b0);
    send_car(2, 1'b0);
    send_car(3, 1'b1);
    // pass-through with the single slot taken
    send_car(2, 1'b0);
    send_car(1, 1'b1);
    // push into a full stack
    send_car(3, 1'b1);
  endtask

  task automatic test_degenerate_config();
    set_config(0, 0);
    send_car(1, 1'b1);
    set_config(0, 2);
    send_car(1, 1'b1);
    // capacity beyond the RAM acts as the RAM depth
    set_config(2047, 2);
    send_car(2, 1'b0);
    send_car(1, 1'b1);
    set_config(1, 2097151);
    send_car(2097151, 1'b1);
  endtask

  // A stack-realizable order of 1..span through at most 'bound' slots, with
  // occasional corruption so the failure paths are reached mid-sequence.
  task automatic run_sequence(int unsigned span, int unsigned bound);
    int unsigned order[$];
    int unsigned held[$];
    int unsigned arrive;
    int unsigned i;
    int unsigned j;
    int unsigned tmp;
    bit          close_seq;
    arrive    = 1;
    close_seq = 1'b1;
    while (order.size() < span) begin
      if (arrive <= span && held.size() < bound &&
          (held.size() == 0 || $urandom_range(0, 1))) begin
        held.push_back(arrive);
        arrive++;
      end else begin
        order.push_back(held.pop_back());
      end
    end
    if ($urandom_range(0, 99) < 25) begin
      i = $urandom_range(0, span - 1);
      j = $urandom_range(0, span - 1);
      case ($urandom_range(0, 4))
        0: begin
          tmp      = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        1: order[i] = $urandom_range(0, span + 2);
        2: order[i] = $urandom_range(0, 2097151);
        3: order = order[0:i];
        default: close_seq = 1'b0;
      endcase
    end
    foreach (order[k]) send_car(order[k], close_seq && k == order.size() - 1);
  endtask

  // Wide random targets: every target bit toggles, mostly failing beats.
  task automatic run_noise();
    repeat ($urandom_range(1, 4)) send_car($urandom_range(0, 2097151), $urandom_range(0, 1));
  endtask

  task automatic test_random_orders();
    int unsigned goal;
    int unsigned cap;
    int unsigned count;
    int unsigned room;
    int unsigned span;
    int unsigned bound;
    goal = beats_sent + RANDOM_BEATS;
    while (beats_sent < goal) begin
      // a steady stretch of about 150 beats with no stalls on either side
      no_stall = (beats_sent + RANDOM_BEATS / 3 >= goal - RANDOM_BEATS / 3) &&
                 (beats_sent + RANDOM_BEATS / 3 < goal - RANDOM_BEATS / 3 + 150);
      if ($urandom_range(0, 99) < 70) begin
        cap = $urandom_range(1, 8);
      end else begin
        case ($urandom_range(0, 3))
          0:       cap = 0;
          1:       cap = STACK_CAP_MAX;
          2:       cap = 2047;
          default: cap = $urandom_range(1, 2047);
        endcase
      end
      if ($urandom_range(0, 99) < 75) begin
        count = $urandom_range(1, 12);
      end else begin
        case ($urandom_range(0, 3))
          0:       count = 0;
          1:       count = 2097151;
          2:       count = CAR_COUNT_RST;
          default: count = $urandom_range(13, 2097151);
        endcase
      end
      set_config(cap, count);
      room = (cap > STACK_CAP_MAX) ? STACK_CAP_MAX : cap;
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 99) < 8) begin
          run_noise();
        end else begin
          span  = (count >= 1 && count <= 16) ? count : $urandom_range(1, 12);
          // one slot too many now and then, to overfill the stack
          bound = (room == 0) ? 1 : room + ($urandom_range(0, 99) < 20);
          run_sequence(span, bound);
        end
      end
    end
    no_stall = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_config();
    test_small_orders();
    test_tight_stack();
    test_degenerate_config();
    test_random_orders();
    drain();
    repeat (16) @(posedge clk);
    $display("Sent %0d beats over %0d register settings; %0d verdicts checked.",
             beats_sent, settings, verdicts_seen);
    $display("Closed %0d sequences, %0d of them feasible.", finals, feasible_finals);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
